// ----- sv/cfpp_pkg.sv -----
// shared types, constants and helper functions for the cube facet projector
// used by cfpp_div and cube_facet_perspective_projector
package cfpp_pkg;

  localparam int ONE_Q14 = 16384;

  // default values of the top level parameters
  localparam int DEF_MAX_EDGE      = 8;
  localparam int DEF_SCREEN_WIDTH  = 3840;
  localparam int DEF_SCREEN_HEIGHT = 2160;

  // datapath widths
  localparam int LOC_W  = 18;   // local and world coordinates
  localparam int REC_W  = 24;   // reciprocal of the edge count
  localparam int REC_SH = 23;   // reciprocal shift
  localparam int NUM_W  = 46;   // projection numerator
  localparam int DEN_W  = 30;   // projection denominator

  // configuration register indexes
  localparam logic [2:0] REG_COS_PITCH = 3'd0;
  localparam logic [2:0] REG_SIN_PITCH = 3'd1;
  localparam logic [2:0] REG_COS_YAW   = 3'd2;
  localparam logic [2:0] REG_SIN_YAW   = 3'd3;
  localparam logic [2:0] REG_FOCAL     = 3'd4;
  localparam logic [2:0] REG_VIEW_DIST = 3'd5;
  localparam logic [2:0] REG_CUBE_SIZE = 3'd6;

  // configuration reset values
  localparam logic [15:0] RST_COS_PITCH = 16'd14849;
  localparam logic [15:0] RST_SIN_PITCH = 16'd6924;
  localparam logic [15:0] RST_COS_YAW   = 16'd14189;
  localparam logic [15:0] RST_SIN_YAW   = 16'hE000;
  localparam logic [15:0] RST_FOCAL     = 16'd19661;
  localparam logic [15:0] RST_VIEW_DIST = 16'd16384;
  localparam logic [3:0]  RST_CUBE_SIZE = 4'd3;

  // face codes
  localparam logic [2:0] FACE_F = 3'd0;
  localparam logic [2:0] FACE_B = 3'd1;
  localparam logic [2:0] FACE_U = 3'd2;
  localparam logic [2:0] FACE_D = 3'd3;
  localparam logic [2:0] FACE_L = 3'd4;
  localparam logic [2:0] FACE_R = 3'd5;

  // color codes
  localparam logic [2:0] COL_U = 3'd0;
  localparam logic [2:0] COL_D = 3'd1;
  localparam logic [2:0] COL_F = 3'd2;
  localparam logic [2:0] COL_B = 3'd3;
  localparam logic [2:0] COL_L = 3'd4;
  localparam logic [2:0] COL_R = 3'd5;

  typedef struct packed {
    logic [2:0] face_id;
    logic [2:0] row;
    logic [2:0] col;
    logic [2:0] sticker_color;
  } item_t;

  typedef struct packed {
    logic signed [15:0] top_left_x;
    logic signed [15:0] top_left_y;
    logic signed [15:0] top_right_x;
    logic signed [15:0] top_right_y;
    logic signed [15:0] bottom_right_x;
    logic signed [15:0] bottom_right_y;
    logic signed [15:0] bottom_left_x;
    logic signed [15:0] bottom_left_y;
    logic signed [15:0] mean_depth;
    logic [23:0]        fill_rgb;
  } result_t;

  typedef struct packed {
    logic signed [LOC_W-1:0] x;
    logic signed [LOC_W-1:0] y;
    logic signed [LOC_W-1:0] z;
  } point_t;

  // ceil(2^23 / n), exact floor division for numerators below 2^19
  function automatic logic [REC_W-1:0] edge_recip(input logic [4:0] n);
    logic [REC_W-1:0] r;
    case (n)
      5'd2:    r = 24'd4194304;
      5'd3:    r = 24'd2796203;
      5'd4:    r = 24'd2097152;
      5'd5:    r = 24'd1677722;
      5'd6:    r = 24'd1398102;
      5'd7:    r = 24'd1198373;
      5'd8:    r = 24'd1048576;
      5'd9:    r = 24'd932068;
      5'd10:   r = 24'd838861;
      5'd11:   r = 24'd762601;
      5'd12:   r = 24'd699051;
      5'd13:   r = 24'd645278;
      5'd14:   r = 24'd599187;
      5'd15:   r = 24'd559241;
      5'd16:   r = 24'd524288;
      default: r = 24'd4194304;
    endcase
    return r;
  endfunction

  // k * 1.0 / n, truncated toward zero
  function automatic logic signed [LOC_W-1:0] loc_coord(input logic signed [6:0] k,
                                                        input logic [REC_W-1:0] m);
    logic [6:0]        mag;
    logic [20:0]       v;
    logic [44:0]       prod;
    logic [LOC_W-1:0]  q;
    mag  = k[6] ? 7'(-k) : 7'(k);
    v    = {mag, 14'd0};
    prod = 45'(v) * 45'(m);
    q    = LOC_W'(prod >> REC_SH);
    return k[6] ? LOC_W'(-q) : LOC_W'(q);
  endfunction

  // place a local point on a face of the 2-by-2 cube
  function automatic point_t face_point(input logic [2:0] face,
                                        input logic signed [LOC_W-1:0] lx,
                                        input logic signed [LOC_W-1:0] ly);
    point_t p;
    logic signed [LOC_W-1:0] one;
    one = LOC_W'(ONE_Q14);
    case (face)
      FACE_B: begin p.x = -lx; p.y = ly;   p.z = -one; end
      FACE_U: begin p.x = lx;  p.y = one;  p.z = -ly;  end
      FACE_D: begin p.x = lx;  p.y = -one; p.z = ly;   end
      FACE_L: begin p.x = -one; p.y = ly;  p.z = lx;   end
      FACE_R: begin p.x = one; p.y = ly;   p.z = -lx;  end
      default: begin p.x = lx; p.y = ly;   p.z = one;  end
    endcase
    return p;
  endfunction

  function automatic logic [23:0] palette(input logic [2:0] c);
    logic [23:0] rgb;
    case (c)
      COL_U:   rgb = 24'hFFFFFF;
      COL_D:   rgb = 24'hFFFF00;
      COL_F:   rgb = 24'h00FF00;
      COL_B:   rgb = 24'h0000FF;
      COL_L:   rgb = 24'hFFA500;
      COL_R:   rgb = 24'hFF0000;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) r = 16'sh7FFF;
    else if (v < -24'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ----- sv/cfpp_div.sv -----
// pipelined signed divider lane, truncating, saturated to 16-bit signed
// one quotient bit per stage; depends on cfpp_pkg
module cfpp_div import cfpp_pkg::*; #(
  parameter int N_W = NUM_W,
  parameter int D_W = DEN_W
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [N_W-1:0] num,
  input  logic signed [D_W-1:0] den,
  output logic signed [15:0]    quo
);

  localparam int QB    = 16;
  localparam int CMP_W = ((N_W > D_W + QB) ? N_W : D_W + QB) + 1;

  logic [N_W-1:0] rem  [0:QB];
  logic [D_W-1:0] dmag [0:QB];
  logic [QB-1:0]  qb   [0:QB];
  logic           neg  [0:QB];
  logic           ovf  [0:QB];

  logic [N_W-1:0] a_in;
  logic [D_W-1:0] b_in;

  assign a_in = num[N_W-1] ? N_W'(-num) : N_W'(num);
  assign b_in = den[D_W-1] ? D_W'(-den) : D_W'(den);

  // magnitudes and the overflow check
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= a_in;
      dmag[0] <= b_in;
      qb[0]   <= '0;
      neg[0]  <= num[N_W-1] ^ den[D_W-1];
      ovf[0]  <= CMP_W'(a_in) >= (CMP_W'(b_in) << QB);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int K = QB - 1 - s;
    logic [CMP_W-1:0] cand;
    logic             ge;
    assign cand = CMP_W'(dmag[s]) << K;
    assign ge   = CMP_W'(rem[s]) >= cand;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= ge ? N_W'(CMP_W'(rem[s]) - cand) : rem[s];
        dmag[s+1] <= dmag[s];
        qb[s+1]   <= qb[s] | (QB'(ge) << K);
        neg[s+1]  <= neg[s];
        ovf[s+1]  <= ovf[s];
      end
    end
  end

  logic signed [15:0] quo_next;

  always_comb begin
    if (ovf[QB]) begin
      quo_next = neg[QB] ? 16'sh8000 : 16'sh7FFF;
    end else if (!neg[QB]) begin
      quo_next = qb[QB][15] ? 16'sh7FFF : 16'(qb[QB]);
    end else begin
      quo_next = (qb[QB] > 16'd32768) ? 16'sh8000 : 16'(-qb[QB]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= quo_next;
    end
  end

endmodule

// ----- sv/cube_facet_perspective_projector.sv -----
// Cube facet perspective projector: takes one sticker per cycle and returns its four
// projected screen corners, mean depth and fill color. Five stages do corner placement,
// the two view rotations and numerator setup, then eighteen stages form a restoring
// divider lane: a magnitude stage, stages that each retire one quotient bit, and a
// saturating output stage. Throughput is one transaction per cycle; when the output
// is held the whole pipe holds with it. Configuration writes take effect at once and
// are meant for times when the pipe is empty. Depends on cfpp_pkg and cfpp_div.
module cube_facet_perspective_projector import cfpp_pkg::*; #(
  parameter int MAX_EDGE      = DEF_MAX_EDGE,
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result
);

  localparam int DIV_LAT = 18;
  localparam int LAT     = 5 + DIV_LAT;
  localparam logic signed [18:0] SW16 = 19'(16 * SCREEN_WIDTH);
  localparam logic signed [18:0] SH16 = 19'(16 * SCREEN_HEIGHT);

  // configuration registers
  logic signed [15:0] cos_pitch, sin_pitch, cos_yaw, sin_yaw;
  logic [15:0]        focal_length, view_distance;
  logic [3:0]         cube_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_pitch     <= RST_COS_PITCH;
      sin_pitch     <= RST_SIN_PITCH;
      cos_yaw       <= RST_COS_YAW;
      sin_yaw       <= RST_SIN_YAW;
      focal_length  <= RST_FOCAL;
      view_distance <= RST_VIEW_DIST;
      cube_size     <= RST_CUBE_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COS_PITCH: cos_pitch     <= cfg_data;
        REG_SIN_PITCH: sin_pitch     <= cfg_data;
        REG_COS_YAW:   cos_yaw       <= cfg_data;
        REG_SIN_YAW:   sin_yaw       <= cfg_data;
        REG_FOCAL:     focal_length  <= cfg_data;
        REG_VIEW_DIST: view_distance <= cfg_data;
        REG_CUBE_SIZE: cube_size     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [LAT-1:0] vld;
  logic           adv;

  assign adv          = !vld[LAT-1] || result_ready;
  assign item_ready   = adv;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  // stage 1: local corner coordinates
  logic [4:0]              n_edge;
  logic [REC_W-1:0]        recip;
  logic signed [6:0]       k_left, k_right, k_top, k_bottom;
  logic signed [LOC_W-1:0] lx_l1, lx_r1, ly_t1, ly_b1;
  logic [2:0]              face1;
  logic [23:0]             rgb1;

  always_comb begin
    if (cube_size < 4'd2) n_edge = 5'd2;
    else if (5'(cube_size) > 5'(MAX_EDGE)) n_edge = 5'(MAX_EDGE);
    else n_edge = 5'(cube_size);
    recip    = edge_recip(n_edge);
    k_left   = 7'({item.col, 1'b0}) - 7'(n_edge);
    k_right  = k_left + 7'sd2;
    k_top    = 7'(n_edge) - 7'({item.row, 1'b0});
    k_bottom = k_top - 7'sd2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx_l1 <= loc_coord(k_left, recip);
      lx_r1 <= loc_coord(k_right, recip);
      ly_t1 <= loc_coord(k_top, recip);
      ly_b1 <= loc_coord(k_bottom, recip);
      face1 <= (item.face_id > FACE_R) ? FACE_F : item.face_id;
      rgb1  <= palette(item.sticker_color);
    end
  end

  // corner order: top-left, top-right, bottom-right, bottom-left
  logic signed [LOC_W-1:0] lx_c [0:3];
  logic signed [LOC_W-1:0] ly_c [0:3];

  assign lx_c[0] = lx_l1;  assign ly_c[0] = ly_t1;
  assign lx_c[1] = lx_r1;  assign ly_c[1] = ly_t1;
  assign lx_c[2] = lx_r1;  assign ly_c[2] = ly_b1;
  assign lx_c[3] = lx_l1;  assign ly_c[3] = ly_b1;

  logic [23:0] rgb2, rgb3, rgb4, rgb5;
  logic signed [23:0] z2_c [0:3];
  logic signed [NUM_W-1:0] nx5 [0:3];
  logic signed [NUM_W-1:0] ny5 [0:3];
  logic signed [DEN_W-1:0] den5 [0:3];
  logic signed [15:0] qx [0:3];
  logic signed [15:0] qy [0:3];

  logic signed [16:0] f_s;
  assign f_s = {1'b0, focal_length};

  for (genvar c = 0; c < 4; c++) begin : g_corner
    point_t p;
    // stage 2: world point and pitch products
    logic signed [LOC_W-1:0] x2r;
    logic signed [33:0]      ycp, zsp, ysp, zcp;
    // stage 3: pitch result and yaw products
    logic signed [34:0]      t_y1, t_z1;
    logic signed [20:0]      y1_c, z1_c, y13;
    logic signed [33:0]      xcy, xsy;
    logic signed [36:0]      z1sy, z1cy;
    // stage 4: yaw result and denominator
    logic signed [37:0]      t_x2, t_z2;
    logic signed [23:0]      x2_c, z2_c4, x24;
    logic signed [20:0]      y14;
    logic signed [24:0]      d_c, d4;
    // stage 5: numerators
    logic signed [40:0]      pxf, pyf;
    logic signed [43:0]      pdw, pdh;

    assign p = face_point(face1, lx_c[c], ly_c[c]);

    always_ff @(posedge clk) begin
      if (adv) begin
        x2r <= p.x;
        ycp <= p.y * cos_pitch;
        zsp <= p.z * sin_pitch;
        ysp <= p.y * sin_pitch;
        zcp <= p.z * cos_pitch;
      end
    end

    assign t_y1 = 35'(ycp) - 35'(zsp);
    assign t_z1 = 35'(ysp) + 35'(zcp);
    assign y1_c = t_y1[34:14];
    assign z1_c = t_z1[34:14];

    always_ff @(posedge clk) begin
      if (adv) begin
        y13  <= y1_c;
        xcy  <= x2r * cos_yaw;
        xsy  <= x2r * sin_yaw;
        z1sy <= z1_c * sin_yaw;
        z1cy <= z1_c * cos_yaw;
      end
    end

    assign t_x2  = 38'(xcy) + 38'(z1sy);
    assign t_z2  = 38'(z1cy) - 38'(xsy);
    assign x2_c  = t_x2[37:14];
    assign z2_c4 = t_z2[37:14];

    // a zero denominator falls back to 1.0, which leaves the focal length unscaled
    always_comb begin
      d_c = 25'(z2_c4) + 25'({view_distance, 2'b00});
      if (d_c == '0) d_c = 25'(ONE_Q14);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x24       <= x2_c;
        y14       <= y13;
        z2_c[c]   <= z2_c4;
        d4        <= d_c;
      end
    end

    assign pxf = x24 * f_s;
    assign pyf = y14 * f_s;
    assign pdw = d4 * SW16;
    assign pdh = d4 * SH16;

    always_ff @(posedge clk) begin
      if (adv) begin
        nx5[c]  <= (NUM_W'(pxf) <<< 1) + NUM_W'(pdw);
        ny5[c]  <= NUM_W'(pdh) - (NUM_W'(pyf) <<< 1);
        den5[c] <= {d4, 5'b00000};
      end
    end

    cfpp_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div_x (
      .clk(clk), .en(adv), .num(nx5[c]), .den(den5[c]), .quo(qx[c])
    );
    cfpp_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div_y (
      .clk(clk), .en(adv), .num(ny5[c]), .den(den5[c]), .quo(qy[c])
    );
  end

  // color and depth ride alongside the corners
  logic signed [25:0] zsum;
  logic signed [15:0] mean5;
  logic [39:0]        side [0:DIV_LAT-1];

  assign zsum = 26'(z2_c[0]) + 26'(z2_c[1]) + 26'(z2_c[2]) + 26'(z2_c[3]);

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb2  <= rgb1;
      rgb3  <= rgb2;
      rgb4  <= rgb3;
      rgb5  <= rgb4;
      mean5 <= sat16(zsum[25:2]);
      side[0] <= {mean5, rgb5};
      for (int s = 1; s < DIV_LAT; s++) begin
        side[s] <= side[s-1];
      end
    end
  end

  always_comb begin
    result.top_left_x     = qx[0];
    result.top_left_y     = qy[0];
    result.top_right_x    = qx[1];
    result.top_right_y    = qy[1];
    result.bottom_right_x = qx[2];
    result.bottom_right_y = qy[2];
    result.bottom_left_x  = qx[3];
    result.bottom_left_y  = qy[3];
    result.mean_depth     = side[DIV_LAT-1][39:24];
    result.fill_rgb       = side[DIV_LAT-1][23:0];
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> vld[0])
    else $error("accepted transaction did not enter the pipe");
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    !item_valid && item_ready |=> !vld[0])
    else $error("pipe entry filled without a transaction");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(vld))
    else $error("pipe moved while the output was held");

endmodule

// ----- test/tb.sv -----
// self-checking bench for cube_facet_perspective_projector: random stickers and view settings
// expected screen corners, depth and color come from a local fixed-point predictor
// depends on cfpp_pkg and the projector rtl
module tb import cfpp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_W = 3840;
  localparam int SCR_H = 2160;
  localparam int EDGE_MAX = 8;
  localparam int WATCHDOG = 20000;
  localparam int PIPE_LAT = 23;

  // predictor of one sticker's projection
  class sticker_scoreboard;
    logic [15:0] cp, sp, cyw, syw, focal, vdist;
    logic [3:0] csize;
    result_t pending[$];
    int errors;

    function void reset_view();
      cp = RST_COS_PITCH; sp = RST_SIN_PITCH; cyw = RST_COS_YAW; syw = RST_SIN_YAW;
      focal = RST_FOCAL; vdist = RST_VIEW_DIST; csize = RST_CUBE_SIZE;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        REG_COS_PITCH: cp = v;
        REG_SIN_PITCH: sp = v;
        REG_COS_YAW:   cyw = v;
        REG_SIN_YAW:   syw = v;
        REG_FOCAL:     focal = v;
        REG_VIEW_DIST: vdist = v;
        REG_CUBE_SIZE: csize = v[3:0];
        default: ;
      endcase
    endfunction

    function longint floor_sh(longint v, int s);
      return v >>> s;
    endfunction

    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void project(int face, longint lx, longint ly,
                          output longint sx, output longint sy, output longint z2);
      longint px, py, pz, y1, z1, x2, d, f;
      longint c_p, s_p, c_y, s_y;
      c_p = longint'($signed(cp)); s_p = longint'($signed(sp));
      c_y = longint'($signed(cyw)); s_y = longint'($signed(syw));
      case (face)
        FACE_B: begin px = -lx; py = ly; pz = -ONE_Q14; end
        FACE_U: begin px = lx; py = ONE_Q14; pz = -ly; end
        FACE_D: begin px = lx; py = -ONE_Q14; pz = ly; end
        FACE_L: begin px = -ONE_Q14; py = ly; pz = lx; end
        FACE_R: begin px = ONE_Q14; py = ly; pz = -lx; end
        default: begin px = lx; py = ly; pz = ONE_Q14; end
      endcase
      y1 = floor_sh(py * c_p - pz * s_p, 14);
      z1 = floor_sh(py * s_p + pz * c_p, 14);
      x2 = floor_sh(px * c_y + z1 * s_y, 14);
      z2 = floor_sh(z1 * c_y - px * s_y, 14);
      f = longint'(focal);
      d = z2 + longint'(vdist) * 4;
      if (d == 0) d = ONE_Q14;
      sx = clamp16((2 * x2 * f + 16 * SCR_W * d) / (32 * d));
      sy = clamp16((-2 * y1 * f + 16 * SCR_H * d) / (32 * d));
    endfunction

    function void note_sticker(item_t it);
      result_t r;
      longint n, i, j, lft, rgt, top, bot, zsum, sx, sy, z;
      longint lx[4], ly[4];
      longint pts[8];
      int face;
      n = csize;
      if (n < 2) n = 2;
      if (n > EDGE_MAX) n = EDGE_MAX;
      i = it.row; j = it.col;
      face = (it.face_id > FACE_R) ? int'(FACE_F) : int'(it.face_id);
      lft = ((2 * j - n) * ONE_Q14) / n;
      rgt = ((2 * j + 2 - n) * ONE_Q14) / n;
      top = ((n - 2 * i) * ONE_Q14) / n;
      bot = ((n - 2 * i - 2) * ONE_Q14) / n;
      lx = '{lft, rgt, rgt, lft};
      ly = '{top, top, bot, bot};
      zsum = 0;
      for (int k = 0; k < 4; k++) begin
        project(face, lx[k], ly[k], sx, sy, z);
        pts[2*k] = sx; pts[2*k+1] = sy;
        zsum += z;
      end
      r.top_left_x = 16'(pts[0]); r.top_left_y = 16'(pts[1]);
      r.top_right_x = 16'(pts[2]); r.top_right_y = 16'(pts[3]);
      r.bottom_right_x = 16'(pts[4]); r.bottom_right_y = 16'(pts[5]);
      r.bottom_left_x = 16'(pts[6]); r.bottom_left_y = 16'(pts[7]);
      r.mean_depth = 16'(clamp16(floor_sh(zsum, 2)));
      case (it.sticker_color)
        COL_U: r.fill_rgb = 24'hFFFFFF;
        COL_D: r.fill_rgb = 24'hFFFF00;
        COL_F: r.fill_rgb = 24'h00FF00;
        COL_B: r.fill_rgb = 24'h0000FF;
        COL_L: r.fill_rgb = 24'hFFA500;
        COL_R: r.fill_rgb = 24'hFF0000;
        default: r.fill_rgb = 24'h000000;
      endcase
      pending = {pending, r};
    endfunction

    function void report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    endfunction

    function void check_result(result_t g);
      result_t e;
      if (pending.size() == 0) begin
        report("unexpected transaction", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (g.top_left_x !== e.top_left_x) report("top_left_x", g.top_left_x, e.top_left_x);
      if (g.top_left_y !== e.top_left_y) report("top_left_y", g.top_left_y, e.top_left_y);
      if (g.top_right_x !== e.top_right_x) report("top_right_x", g.top_right_x, e.top_right_x);
      if (g.top_right_y !== e.top_right_y) report("top_right_y", g.top_right_y, e.top_right_y);
      if (g.bottom_right_x !== e.bottom_right_x)
        report("bottom_right_x", g.bottom_right_x, e.bottom_right_x);
      if (g.bottom_right_y !== e.bottom_right_y)
        report("bottom_right_y", g.bottom_right_y, e.bottom_right_y);
      if (g.bottom_left_x !== e.bottom_left_x)
        report("bottom_left_x", g.bottom_left_x, e.bottom_left_x);
      if (g.bottom_left_y !== e.bottom_left_y)
        report("bottom_left_y", g.bottom_left_y, e.bottom_left_y);
      if (g.mean_depth !== e.mean_depth) report("mean_depth", g.mean_depth, e.mean_depth);
      if (g.fill_rgb !== e.fill_rgb) report("fill_rgb", g.fill_rgb, e.fill_rgb);
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic item_valid = 0, item_ready;
  item_t item = '0;
  logic result_valid, result_ready = 0;
  result_t result;

  sticker_scoreboard sb = new();
  bit sender_idle_on = 1, sink_idle_on = 1, hold_sink = 0;
  int quiet_cycles = 0;

  cube_facet_perspective_projector dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // checks and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(result);
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("timeout");
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // receiver with random stall bursts and an optional long hold-off
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_sink) begin
        result_ready <= 0;
        for (int k = 0; k < 300; k++) @(posedge clk);
        hold_sink = 0;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        result_ready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        result_ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_sticker(item_t it);
    int n;
    if (sender_idle_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      item_valid <= 0;
      repeat (n) @(posedge clk);
    end
    item_valid <= 1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_sticker(it);
  endtask

  task automatic drain();
    item_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  // the enable drops between writes
  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic write_view(logic [15:0] c_p, logic [15:0] s_p, logic [15:0] c_y,
                            logic [15:0] s_y, logic [15:0] f, logic [15:0] vd,
                            logic [15:0] cs);
    write_reg(REG_COS_PITCH, c_p);
    write_reg(REG_SIN_PITCH, s_p);
    write_reg(REG_COS_YAW, c_y);
    write_reg(REG_SIN_YAW, s_y);
    write_reg(REG_FOCAL, f);
    write_reg(REG_VIEW_DIST, vd);
    write_reg(REG_CUBE_SIZE, cs);
  endtask

  function automatic item_t rand_sticker(int edge_n);
    item_t it;
    it.face_id = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    if ($urandom_range(0, 7) == 0) begin
      it.row = 3'($urandom); it.col = 3'($urandom);
    end else begin
      it.row = 3'($urandom_range(0, edge_n - 1)); it.col = 3'($urandom_range(0, edge_n - 1));
    end
    it.sticker_color = 3'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(0, 4))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  initial begin
    item_t it;
    int sz;
    sb.reset_view();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every face and color, edge stickers, out-of-range rows
    for (int k = 0; k < 8; k++) begin
      it.face_id = 3'(k); it.row = 3'(k % 3); it.col = 3'(2 - (k % 3));
      it.sticker_color = 3'(k);
      send_sticker(it);
    end
    send_sticker('{face_id: FACE_F, row: 3'd7, col: 3'd7, sticker_color: COL_R});
    send_sticker('{face_id: FACE_U, row: 3'd0, col: 3'd7, sticker_color: COL_U});
    drain();

    // zero denominator: straight view, no view distance, left corners of the L face at z = 0
    write_view(16'sd16384, 16'd0, 16'sd16384, 16'd0, 16'hFFFF, 16'd0, 16'd2);
    send_sticker('{face_id: FACE_L, row: 3'd0, col: 3'd1, sticker_color: COL_B});
    send_sticker('{face_id: FACE_F, row: 3'd1, col: 3'd1, sticker_color: COL_F});
    drain();
    write_reg(REG_VIEW_DIST, 16'd4096);
    send_sticker('{face_id: FACE_B, row: 3'd1, col: 3'd0, sticker_color: 3'd6});
    drain();
    // cube size below and above range, extreme trig and focal
    write_view(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 16'd0, 16'hFFFF, 16'd0);
    send_sticker('{face_id: FACE_L, row: 3'd1, col: 3'd0, sticker_color: COL_L});
    send_sticker('{face_id: FACE_R, row: 3'd7, col: 3'd0, sticker_color: 3'd7});
    drain();
    write_view(16'sd1, -16'sd1, 16'd0, 16'sd1000, 16'hFFFF, 16'd4100, 16'd15);
    for (int k = 0; k < 6; k++) send_sticker(rand_sticker(8));
    drain();
    // unknown register index is ignored by the block
    cfg_we <= 1; cfg_index <= 3'd7; cfg_data <= 16'hFFFF;
    @(posedge clk);
    cfg_we <= 0;

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) sb.set_reg(REG_CUBE_SIZE, 16'(sb.csize)); // keep settings from directed part
      else begin
        sz = (ph % 4 == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8);
        write_view(rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                   ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40000)),
                   ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                     16'($urandom_range(4096, 65535)), 16'(sz));
      end
      sz = (sb.csize < 2) ? 2 : ((sb.csize > 8) ? 8 : int'(sb.csize));
      if (ph == 10) begin
        sender_idle_on = 0; sink_idle_on = 0;
      end
      if (ph == 3) begin
        hold_sink = 1;
        sender_idle_on = 0;
      end
      for (int k = 0; k < 90; k++) send_sticker(rand_sticker(sz));
      sender_idle_on = (ph < 10);
      drain();
    end

    repeat (PIPE_LAT + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
sv/cfpp_pkg.sv
sv/cfpp_div.sv
sv/cube_facet_perspective_projector.sv
test/tb.sv
